>>> design/fpc_pkg.sv
// ---------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the frequent pattern compression line size
// estimator.
// ---------------------------------------------------------------------------
package fpc_pkg;

	localparam int WORD_W  = 32;
	localparam int CLASS_W = 3;
	localparam int BITS_W  = 6;
	localparam int TOTAL_W = 10;
	localparam int PFX_W   = 3;

	localparam logic [CLASS_W-1:0] CLS_ZERO   = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_SEXT4  = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_SEXT8  = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_SEXT16 = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_LOHALF = 3'd4;
	localparam logic [CLASS_W-1:0] CLS_BYTES  = 3'd5;
	localparam logic [CLASS_W-1:0] CLS_REPEAT = 3'd6;
	localparam logic [CLASS_W-1:0] CLS_UNCOMP = 3'd7;

	localparam logic [BITS_W-1:0] ZERO_PAYLOAD = 6'd3;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 10'd1023;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [BITS_W-1:0]  payload;
		logic               last;
	} fpc_item_t;

endpackage

>>> design/fpc_classify.sv
// ---------------------------------------------------------------------------
// fpc_classify
// Front end: accepts words and picks the first matching frequent pattern
// together with its payload size.
// ---------------------------------------------------------------------------
module fpc_classify (
	input  logic [fpc_pkg::WORD_W-1:0] data_word,
	input  logic                       last_word,
	output fpc_pkg::fpc_item_t         item
);
	import fpc_pkg::*;

	logic [WORD_W-1:0] m4;
	logic [WORD_W-1:0] m8;
	logic [WORD_W-1:0] m16;
	logic [WORD_W-1:0] mbh;
	logic              fit4;
	logic              fit8;
	logic              fit16;
	logic              lohalf;
	logic              bytehalves;
	logic              repeated;

	assign m4  = data_word & 32'hFFFF_FFF8;
	assign m8  = data_word & 32'hFFFF_FF80;
	assign m16 = data_word & 32'hFFFF_8000;
	assign mbh = data_word & 32'hFF80_FF80;

	assign fit4       = (m4 == '0) || (m4 == 32'hFFFF_FFF8);
	assign fit8       = (m8 == '0) || (m8 == 32'hFFFF_FF80);
	assign fit16      = (m16 == '0) || (m16 == 32'hFFFF_8000);
	assign lohalf     = (data_word & 32'h0000_FFFF) == '0;
	assign bytehalves = (mbh == '0) || (mbh == 32'hFF80_0000) ||
	                    (mbh == 32'h0000_FF80) || (mbh == 32'hFF80_FF80);
	assign repeated   = (data_word[7:0] == data_word[15:8]) &&
	                    (data_word[7:0] == data_word[23:16]) &&
	                    (data_word[7:0] == data_word[31:24]);

	always_comb begin
		item.last = last_word;
		if (data_word == '0) begin
			item.cls     = CLS_ZERO;
			item.payload = ZERO_PAYLOAD;
		end else if (fit4) begin
			item.cls     = CLS_SEXT4;
			item.payload = 6'd4;
		end else if (fit8) begin
			item.cls     = CLS_SEXT8;
			item.payload = 6'd8;
		end else if (fit16) begin
			item.cls     = CLS_SEXT16;
			item.payload = 6'd16;
		end else if (lohalf) begin
			item.cls     = CLS_LOHALF;
			item.payload = 6'd16;
		end else if (bytehalves) begin
			item.cls     = CLS_BYTES;
			item.payload = 6'd16;
		end else if (repeated) begin
			item.cls     = CLS_REPEAT;
			item.payload = 6'd8;
		end else begin
			item.cls     = CLS_UNCOMP;
			item.payload = 6'd32;
		end
	end

endmodule

>>> design/fpc_queue.sv
// ---------------------------------------------------------------------------
// fpc_queue
// Two-entry queue of classified items between the front and back ends.
// ---------------------------------------------------------------------------
module fpc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  fpc_pkg::fpc_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output fpc_pkg::fpc_item_t pop_item
);
	import fpc_pkg::*;

	fpc_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> design/fpc_accum.sv
// ---------------------------------------------------------------------------
// fpc_accum
// Back end: charges each item, tracks zero runs and the saturating line
// total, and holds the result in an output register.
// ---------------------------------------------------------------------------
module fpc_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [fpc_pkg::PFX_W-1:0]   cfg_wdata,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  fpc_pkg::fpc_item_t          item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fpc_pkg::CLASS_W-1:0] pattern_class,
	output logic [fpc_pkg::BITS_W-1:0]  word_bits,
	output logic [fpc_pkg::TOTAL_W-1:0] line_bits,
	output logic                        line_done
);
	import fpc_pkg::*;

	logic [PFX_W-1:0]   prefix_bits_q;
	logic               in_run_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	logic [CLASS_W-1:0] cls_q;
	logic [BITS_W-1:0]  bits_q;
	logic [TOTAL_W-1:0] line_q;
	logic               done_q;
	logic               take;
	logic               is_zero;
	logic [BITS_W-1:0]  bits;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] sat;

	assign item_ready = !out_valid_q || out_ready;
	assign take       = item_valid && item_ready;
	assign is_zero    = (item.cls == CLS_ZERO);

	always_comb begin
		if (is_zero && in_run_q) begin
			bits = '0;
		end else begin
			bits = item.payload + BITS_W'(prefix_bits_q);
		end
		sum = {1'b0, total_q} + (TOTAL_W + 1)'(bits);
		sat = (sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_bits_q <= 3'd3;
			in_run_q      <= 1'b0;
			total_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				prefix_bits_q <= cfg_wdata;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				if (item.last) begin
					in_run_q <= 1'b0;
					total_q  <= '0;
				end else begin
					in_run_q <= is_zero;
					total_q  <= sat;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_q  <= item.cls;
			bits_q <= bits;
			line_q <= sat;
			done_q <= item.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign pattern_class = cls_q;
	assign word_bits     = bits_q;
	assign line_bits     = line_q;
	assign line_done     = done_q;

endmodule

>>> design/fpc_line_size_estimator.sv
// ---------------------------------------------------------------------------
// fpc_line_size_estimator
// Estimates the frequent pattern compressed size of a cache line, one word
// per item.
// ---------------------------------------------------------------------------
// Each input item on s_axis carries one 32-bit word of a line in tdata, and
// tlast marks the final word of the line. Each input item gives exactly one
// result item on m_axis with the chosen pattern, the bits charged for the
// word and the running line size; tlast there repeats the input's tlast, so
// the size shown with it is the final size of the line.
// A word passes the classifier straight into a two-entry queue, and the
// accumulator takes it from there into its output register. One word is
// taken per cycle for as long as results are taken; the accumulator's
// combinational add and saturate sets that rate.
// When m_axis stalls, the output register holds its result and the queue
// fills; s_axis_tready falls once both queue entries are in use.
// Reset empties the queue and the output, clears the line total and the
// zero run, and sets the prefix size to 3. The user writes the prefix size
// by cfg_wen and cfg_wdata only while no line is in flight (not enforced).
// ---------------------------------------------------------------------------
module fpc_line_size_estimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // data_word[31:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // pattern_class[2:0], word_bits[8:3],
	                                   // line_bits[18:9], zero fill[23:19]
	output logic        m_axis_tlast
);
	import fpc_pkg::*;

	fpc_item_t          front_item;
	fpc_item_t          back_item;
	logic               back_valid;
	logic               back_ready;
	logic [CLASS_W-1:0] pattern_class;
	logic [BITS_W-1:0]  word_bits;
	logic [TOTAL_W-1:0] line_bits;

	fpc_classify u_classify (
		.data_word (s_axis_tdata),
		.last_word (s_axis_tlast),
		.item      (front_item)
	);

	fpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	fpc_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.item_valid    (back_valid),
		.item_ready    (back_ready),
		.item          (back_item),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.pattern_class (pattern_class),
		.word_bits     (word_bits),
		.line_bits     (line_bits),
		.line_done     (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, line_bits, word_bits, pattern_class};

endmodule
